### src/decimal_string_to_int_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal string parser
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_INT_PARSER_MACROS_SVH
`define DECIMAL_STRING_TO_INT_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg
// Types and constants shared by the decimal string parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

  // Default depth of the queue between classifier and accumulator
  localparam int DSI_FIFO_DEPTH = 4;

  // Character constants
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Character classes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_SPACE = 3'd1;
  localparam logic [2:0] CLS_DIGIT = 3'd2;
  localparam logic [2:0] CLS_PLUS  = 3'd3;
  localparam logic [2:0] CLS_MINUS = 3'd4;
  localparam logic [2:0] CLS_UNDER = 3'd5;
  localparam logic [2:0] CLS_OTHER = 3'd6;

  // Input item
  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic               ok;
    logic signed [63:0] value;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } cls_item_t;

endpackage

`default_nettype wire

### src/dsi_front.sv
// ----------------------------------------------------------------------------
// dsi_front
// Classifies each incoming byte into space, digit, sign, underscore or other; no_char items get none.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_front (
  input  dsi_pkg::in_item_t  in_item,
  output dsi_pkg::cls_item_t cls_item
);
  import dsi_pkg::*;

  logic is_space;
  logic is_digit;
  logic [7:0] dig_byte;

  // Recognize whitespace and decimal digits
  assign is_space = (in_item.ch == CH_SPACE) || (in_item.ch == CH_TAB) ||
                    (in_item.ch == CH_LF)    || (in_item.ch == CH_CR)  ||
                    (in_item.ch == CH_FF)    || (in_item.ch == CH_VT);
  assign is_digit = (in_item.ch >= CH_ZERO) && (in_item.ch <= CH_NINE);
  assign dig_byte = in_item.ch - CH_ZERO;

  // Pick the class; an item without a character carries none
  always_comb begin
    cls_item.last  = in_item.last;
    cls_item.digit = dig_byte[3:0];
    priority if (in_item.no_char) begin
      cls_item.cls = CLS_NONE;
    end else if (is_space) begin
      cls_item.cls = CLS_SPACE;
    end else if (is_digit) begin
      cls_item.cls = CLS_DIGIT;
    end else if (in_item.ch == CH_PLUS) begin
      cls_item.cls = CLS_PLUS;
    end else if (in_item.ch == CH_MINUS) begin
      cls_item.cls = CLS_MINUS;
    end else if (in_item.ch == CH_UNDER) begin
      cls_item.cls = CLS_UNDER;
    end else begin
      cls_item.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

### src/dsi_fifo.sv
// ----------------------------------------------------------------------------
// dsi_fifo
// Short queue of classified items between the classifier and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_fifo #(
  parameter int DEPTH = dsi_pkg::DSI_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dsi_pkg::cls_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output dsi_pkg::cls_item_t rd_item,
  output logic               empty
);
  import dsi_pkg::*;

`include "decimal_string_to_int_parser_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_item_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              wr_en;
  logic              rd_en;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `DSI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "queue count exceeds depth")
  `DSI_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_r == $past(count_r) + 1'b1, "queue count did not rise")
  `DSI_ASSERT_NEXT(a_count_hold, wr_en && rd_en, $stable(count_r), "queue count moved on write and read")

endmodule

`default_nettype wire

### src/dsi_back.sv
// ----------------------------------------------------------------------------
// dsi_back
// Runs the parse state machine, accumulates the magnitude, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dsi_pkg::cls_item_t  q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output dsi_pkg::out_item_t  out_item,
  output logic                out_empty,
  input  logic                out_pop
);
  import dsi_pkg::*;

`include "decimal_string_to_int_parser_macros.svh"

  // Parse phases
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_DIGIT = 3'd2;
  localparam logic [2:0] PH_UNDER = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;
  localparam logic [2:0] PH_FAIL  = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [62:0] mag_r, mag_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [66:0] mag_ext;
  logic [66:0] prod;
  logic        ovf;
  logic        take;
  logic        good;
  logic [63:0] mag_wide;

  // Take an item unless it closes a string while the result slot stays full
  assign take  = !q_empty && (!q_item.last || !out_valid_r || out_pop);
  assign q_pop = take;

  // Times ten plus digit, overflow past 2^63-1
  assign mag_ext = {4'b0, mag_r};
  assign prod    = (mag_ext << 3) + (mag_ext << 1) + {63'b0, q_item.digit};
  assign ovf     = |prod[66:63];

  // Step the phase for one character
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    if (q_item.cls != CLS_NONE) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (q_item.cls == CLS_SPACE) begin
            phase_nxt = PH_LEAD;
          end else if (q_item.cls == CLS_PLUS || q_item.cls == CLS_MINUS) begin
            neg_nxt   = (q_item.cls == CLS_MINUS);
            phase_nxt = PH_SIGN;
          end else if (q_item.cls == CLS_DIGIT) begin
            phase_nxt = ovf ? PH_FAIL : PH_DIGIT;
            mag_nxt   = ovf ? mag_r : prod[62:0];
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_SIGN, PH_UNDER: begin
          if (q_item.cls == CLS_DIGIT) begin
            phase_nxt = ovf ? PH_FAIL : PH_DIGIT;
            mag_nxt   = ovf ? mag_r : prod[62:0];
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_DIGIT: begin
          if (q_item.cls == CLS_DIGIT) begin
            phase_nxt = ovf ? PH_FAIL : PH_DIGIT;
            mag_nxt   = ovf ? mag_r : prod[62:0];
          end else if (q_item.cls == CLS_UNDER) begin
            phase_nxt = PH_UNDER;
          end else if (q_item.cls == CLS_SPACE) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_TRAIL: begin
          phase_nxt = (q_item.cls == CLS_SPACE) ? PH_TRAIL : PH_FAIL;
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
    end
  end

  // Form the result from the stepped state
  assign good     = (phase_nxt == PH_DIGIT) || (phase_nxt == PH_TRAIL);
  assign mag_wide = {1'b0, mag_nxt};

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (take && q_item.last) begin
      out_valid_nxt      = 1'b1;
      out_item_nxt.ok    = good;
      out_item_nxt.value = !good ? 64'sd0 :
                           (neg_nxt ? -$signed(mag_wide) : $signed(mag_wide));
    end
  end

  // State registers: clear after the closing item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (q_item.last) begin
          phase_r <= PH_LEAD;
          neg_r   <= 1'b0;
          mag_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          mag_r   <= mag_nxt;
        end
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_item  = out_item_r;
  assign out_empty = !out_valid_r;

  `DSI_ASSERT_NOW(a_fail_zero, out_valid_r && !out_item_r.ok, out_item_r.value == 64'sd0, "failed result carries nonzero value")
  `DSI_ASSERT_NEXT(a_close_clears, take && q_item.last, phase_r == PH_LEAD && mag_r == '0 && !neg_r, "state not cleared after string end")
  `DSI_ASSERT_NOW(a_no_overwrite, take && q_item.last, !out_valid_r || out_pop, "result overwritten before pop")

endmodule

`default_nettype wire

### src/decimal_string_to_int_parser.sv
// ----------------------------------------------------------------------------
// decimal_string_to_int_parser
// Streams one byte per item and returns ok and a signed 64-bit value per string.
// ----------------------------------------------------------------------------
//   channel   ports                          item fields
//   input     in_push / in_full / in_item    ch, no_char, last
//   result    out_empty / out_pop / out_item ok, value
//
// One item per cycle sustained while a held result stalls no closing item; the
// accumulator step (times ten, add digit, overflow compare) sets that figure.
// A result appears on out_item the cycle after its closing item leaves the queue.
// Synchronous active-low reset clears the queue, the parse state and the result.
// A held result stalls only closing items; the queue keeps filling meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_string_to_int_parser #(
  parameter int FIFO_DEPTH = dsi_pkg::DSI_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  dsi_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output dsi_pkg::out_item_t out_item
);
  import dsi_pkg::*;

  cls_item_t cls_in;
  cls_item_t cls_head;
  logic      q_empty;
  logic      q_pop;

  // Classify incoming bytes
  dsi_front u_front (
    .in_item  (in_item),
    .cls_item (cls_in)
  );

  // Decouple classifier from accumulator
  dsi_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (cls_in),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (cls_head),
    .empty   (q_empty)
  );

  // Parse and hold results
  dsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (cls_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire
